// ===== design/hashed_set_assoc_hit_cache_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hashed set-associative hit cache
// Implication forms on the block clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HASHED_SET_ASSOC_HIT_CACHE_MACROS_SVH
`define HASHED_SET_ASSOC_HIT_CACHE_MACROS_SVH

// same-cycle implication
`define HSAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HSAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hsac_pkg.sv =====
// ----------------------------------------------------------------------------
// hsac_pkg
// Shared codes, request type and hash helper for the hit cache.
// ----------------------------------------------------------------------------
package hsac_pkg;

    localparam int KEY_W  = 64;
    localparam int HIT_W  = 32;
    localparam int SLOT_W = 4;

    localparam logic [2:0] CMD_LOOKUP     = 3'd0;
    localparam logic [2:0] CMD_LOOKUP_INS = 3'd1;
    localparam logic [2:0] CMD_UPD_EN     = 3'd2;
    localparam logic [2:0] CMD_UPD_DIS    = 3'd3;
    localparam logic [2:0] CMD_REMOVE     = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;

    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [1:0] K_ACCESS  = 2'd0;
    localparam logic [1:0] K_CLEAR   = 2'd1;
    localparam logic [1:0] K_INVALID = 2'd2;

    localparam logic [7:0] REG_CACHE_ON  = 8'd0;
    localparam logic [7:0] REG_HASH_SEED = 8'd1;

    localparam logic [31:0] HASH_INIT = 32'hdeadbeef + 32'd8;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       st;
        logic [2:0]       cmd;
        logic [KEY_W-1:0] key;
    } t_req;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

// ===== design/hsac_front.sv =====
// ----------------------------------------------------------------------------
// hsac_front
// Two-stage front end: classifies each item and computes its bucket hash.
// ----------------------------------------------------------------------------
module hsac_front
    import hsac_pkg::*;
#(
    parameter int BUCKET_BITS = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2:0]             i_command,
    input  logic [KEY_W-1:0]       i_key_address,
    input  logic                   i_cache_on,
    input  logic [31:0]            i_hash_seed,
    output logic                   o_req_valid,
    input  logic                   i_req_ready,
    output t_req                   o_req,
    output logic [BUCKET_BITS-1:0] o_bkt
);

    logic       r_s1_v, r_s2_v;
    t_req       r_s1_req, r_s2_req;
    logic [31:0] r_s1_a, r_s1_b, r_s1_c;
    logic [BUCKET_BITS-1:0] r_s2_bkt;

    logic        s1_go, s2_go;
    logic [31:0] a0, b0, c0, c1, a1, b1;
    logic [31:0] c2, a2, b2, c3;
    t_req        n_req;

    assign s2_go   = !r_s2_v || i_req_ready;
    assign s1_go   = !r_s1_v || s2_go;
    assign o_ready = s1_go;

    // first three mixing rounds
    always_comb begin
        c0 = HASH_INIT + i_hash_seed;
        a0 = c0 + i_key_address[31:0];
        b0 = c0 + i_key_address[63:32];
        c1 = (c0 ^ b0) - rotl(b0, 14);
        a1 = (a0 ^ c1) - rotl(c1, 11);
        b1 = (b0 ^ a1) - rotl(a1, 25);
    end

    // remaining rounds
    always_comb begin
        c2 = (r_s1_c ^ r_s1_b) - rotl(r_s1_b, 16);
        a2 = (r_s1_a ^ c2) - rotl(c2, 4);
        b2 = (r_s1_b ^ a2) - rotl(a2, 14);
        c3 = (c2 ^ b2) - rotl(b2, 24);
    end

    always_comb begin
        n_req.cmd = i_command;
        n_req.key = i_key_address;
        if (i_command == CMD_CLEAR) begin
            n_req.kind = K_CLEAR;
            n_req.st   = i_cache_on ? ST_FOUND : ST_INVALID;
        end else if (!i_cache_on || i_command > CMD_CLEAR || i_key_address == '0) begin
            n_req.kind = K_INVALID;
            n_req.st   = ST_INVALID;
        end else begin
            n_req.kind = K_ACCESS;
            n_req.st   = ST_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s1_go) begin
                r_s1_v <= i_valid;
            end
            if (s2_go) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s1_req <= n_req;
            r_s1_a   <= a1;
            r_s1_b   <= b1;
            r_s1_c   <= c1;
        end
        if (s2_go) begin
            r_s2_req <= r_s1_req;
            r_s2_bkt <= c3[BUCKET_BITS-1:0];
        end
    end

    assign o_req_valid = r_s2_v;
    assign o_req       = r_s2_req;
    assign o_bkt       = r_s2_bkt;

endmodule

// ===== design/hsac_queue.sv =====
// ----------------------------------------------------------------------------
// hsac_queue
// Two-entry FIFO between front and back end.
// ----------------------------------------------------------------------------
module hsac_queue
    import hsac_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== design/hsac_back.sv =====
// ----------------------------------------------------------------------------
// hsac_back
// Back end: bucket memories, read-modify-write sequencer, clear sweep.
// ----------------------------------------------------------------------------
module hsac_back
    import hsac_pkg::*;
#(
    parameter int BUCKET_BITS = 14,
    parameter int WAYS        = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_ready,
    input  t_req                   i_req,
    input  logic [BUCKET_BITS-1:0] i_bkt,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_status,
    output logic [HIT_W-1:0]       o_hit_count,
    output logic                   o_init
);

    localparam int NB   = 1 << BUCKET_BITS;
    localparam int WW   = $clog2(WAYS);
    localparam int CW   = $clog2(WAYS + 1);
    localparam int KROW = WAYS * KEY_W;
    localparam int HROW = WAYS * HIT_W;
    localparam int MROW = WAYS * SLOT_W + WAYS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EX   = 2'd2;
    localparam logic [1:0] S_CLR  = 2'd3;

    logic [KROW-1:0] m_keys [NB];
    logic [HROW-1:0] m_hits [NB];
    logic [MROW-1:0] m_meta [NB];

    logic [KROW-1:0] r_rd_k;
    logic [HROW-1:0] r_rd_h;
    logic [MROW-1:0] r_rd_m;

    logic [1:0]             r_state;
    logic                   r_init;
    t_req                   r_req;
    logic [BUCKET_BITS-1:0] r_bkt, r_clr;
    logic                   r_ov;
    logic [1:0]             r_st;
    logic [HIT_W-1:0]       r_hc;

    logic out_free, pop;

    // row views
    logic [KEY_W-1:0]  kw [WAYS];
    logic [HIT_W-1:0]  hv [WAYS];
    logic [SLOT_W-1:0] ord [WAYS];
    logic [WAYS-1:0]   vld;

    logic [WAYS-1:0]   match;
    logic              found;
    logic [WW-1:0]     hw, fw, iw;
    logic [CW-1:0]     nv, islot;
    logic              full;
    logic [CW-1:0]     ds;
    logic              ds_ok;
    logic [SLOT_W-1:0] dord [WAYS];
    logic [SLOT_W-1:0] sord [WAYS];
    logic [SLOT_W-1:0] iord [WAYS];
    logic [HIT_W-1:0]  h, nh;

    logic              we_k, we_h, we_m;
    logic [KROW-1:0]   wd_k;
    logic [HROW-1:0]   wd_h;
    logic [MROW-1:0]   wd_m, ex_m;
    logic [BUCKET_BITS-1:0] m_waddr;
    logic [1:0]        ex_st;
    logic [HIT_W-1:0]  ex_hc;
    logic              is_ins, is_hit, is_del;

    assign out_free  = !r_ov || i_out_ready;
    assign o_q_ready = (r_state == S_IDLE) && out_free;
    assign pop       = i_q_valid && o_q_ready;

    always_comb begin
        vld = r_rd_m[WAYS-1:0];
        for (int w = 0; w < WAYS; w++) begin
            kw[w]    = r_rd_k[w*KEY_W +: KEY_W];
            hv[w]    = r_rd_h[w*HIT_W +: HIT_W];
            ord[w]   = r_rd_m[WAYS + w*SLOT_W +: SLOT_W];
            match[w] = vld[w] && (kw[w] == r_req.key);
        end
    end

    // way search, fill count, order list edits
    always_comb begin
        found = |match;
        hw    = '0;
        fw    = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hw = WW'(w);
            end
            if (!vld[w]) begin
                fw = WW'(w);
            end
        end
        nv   = CW'($countones(vld));
        full = (nv >= CW'(WAYS));

        ds    = '0;
        ds_ok = 1'b0;
        for (int s = WAYS - 1; s >= 0; s--) begin
            if (CW'(s) < nv && ord[s] == SLOT_W'(hw)) begin
                ds    = CW'(s);
                ds_ok = 1'b1;
            end
        end

        // drop the deleted slot, later slots move down
        for (int s = 0; s < WAYS; s++) begin
            dord[s] = ord[s];
            if (ds_ok) begin
                if (CW'(s) >= ds && CW'(s + 1) < nv) begin
                    dord[s] = ord[(s + 1) % WAYS];
                end
                if (CW'(s + 1) == nv) begin
                    dord[s] = '0;
                end
            end
        end

        // drop the oldest slot for an eviction
        for (int s = 0; s < WAYS; s++) begin
            sord[s] = (s + 1 < WAYS) ? ord[(s + 1) % WAYS] : '0;
        end

        iw    = full ? ord[0][WW-1:0] : fw;
        islot = full ? CW'(WAYS - 1) : nv;
        for (int s = 0; s < WAYS; s++) begin
            iord[s] = full ? sord[s] : ord[s];
            if (CW'(s) == islot) begin
                iord[s] = SLOT_W'(iw);
            end
        end
    end

    // counter update
    always_comb begin
        h  = hv[hw];
        nh = h;
        if (r_req.cmd == CMD_UPD_EN) begin
            if (h != HIT_MAX) begin
                nh = h + 1'b1;
            end
        end else if (h != '0 && h != HIT_MAX) begin
            nh = h + 1'b1;
        end
    end

    always_comb begin
        is_hit = found && (r_req.cmd == CMD_LOOKUP || r_req.cmd == CMD_LOOKUP_INS ||
                           r_req.cmd == CMD_UPD_EN);
        is_del = found && (r_req.cmd == CMD_UPD_DIS || r_req.cmd == CMD_REMOVE);
        is_ins = !found && (r_req.cmd == CMD_LOOKUP_INS);

        wd_k = r_rd_k;
        wd_h = r_rd_h;
        for (int w = 0; w < WAYS; w++) begin
            if (WW'(w) == iw) begin
                wd_k[w*KEY_W +: KEY_W] = r_req.key;
            end
            if (is_hit && WW'(w) == hw) begin
                wd_h[w*HIT_W +: HIT_W] = nh;
            end
            if (is_ins && WW'(w) == iw) begin
                wd_h[w*HIT_W +: HIT_W] = '0;
            end
        end

        ex_m = r_rd_m;
        for (int s = 0; s < WAYS; s++) begin
            if (is_del) begin
                ex_m[WAYS + s*SLOT_W +: SLOT_W] = dord[s];
                if (WW'(s) == hw) begin
                    ex_m[s] = 1'b0;
                end
            end else begin
                ex_m[WAYS + s*SLOT_W +: SLOT_W] = iord[s];
                if (WW'(s) == iw) begin
                    ex_m[s] = 1'b1;
                end
            end
        end

        ex_st = found ? ST_FOUND : ST_MISS;
        ex_hc = is_hit ? nh : '0;

        we_k    = (r_state == S_EX) && is_ins;
        we_h    = (r_state == S_EX) && (is_ins || is_hit);
        we_m    = ((r_state == S_EX) && (is_ins || is_del)) || (r_state == S_CLR);
        wd_m    = (r_state == S_CLR) ? '0 : ex_m;
        m_waddr = (r_state == S_CLR) ? r_clr : r_bkt;
    end

    always_ff @(posedge i_clk) begin
        if (we_k) begin
            m_keys[r_bkt] <= wd_k;
        end
        r_rd_k <= m_keys[r_bkt];
    end

    always_ff @(posedge i_clk) begin
        if (we_h) begin
            m_hits[r_bkt] <= wd_h;
        end
        r_rd_h <= m_hits[r_bkt];
    end

    always_ff @(posedge i_clk) begin
        if (we_m) begin
            m_meta[m_waddr] <= wd_m;
        end
        r_rd_m <= m_meta[r_bkt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init  <= 1'b1;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_req <= i_req;
                        r_bkt <= i_bkt;
                        case (i_req.kind)
                            K_ACCESS: r_state <= S_RD;
                            K_CLEAR: begin
                                r_state <= S_CLR;
                                r_clr   <= '0;
                            end
                            default: begin
                                r_ov <= 1'b1;
                                r_st <= i_req.st;
                                r_hc <= '0;
                            end
                        endcase
                    end
                end
                S_RD: r_state <= S_EX;
                S_EX: begin
                    r_ov    <= 1'b1;
                    r_st    <= ex_st;
                    r_hc    <= ex_hc;
                    r_state <= S_IDLE;
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                        r_init  <= 1'b0;
                        if (!r_init) begin
                            r_ov <= 1'b1;
                            r_st <= r_req.st;
                            r_hc <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_st;
    assign o_hit_count = r_hc;
    assign o_init      = r_init;

endmodule

// ===== design/hashed_set_assoc_hit_cache.sv =====
// ----------------------------------------------------------------------------
// hashed_set_assoc_hit_cache
// Hit-counting address cache, 2^BUCKET_BITS buckets of WAYS ways. Each item
// carries a command and a 64-bit address; each gives exactly one result item
// (status, hit count). A two-stage front end classifies the item and forms
// the seeded bucket hash; a two-entry queue decouples it from the back end,
// which reads the whole bucket row, compares all ways at once and writes the
// row back, evicting the oldest entry in insertion order when full. An
// access item goes through issue, memory read, and compare and write; an
// invalid item is answered at issue. A clear item, and the pass that follows
// reset, sweep the bucket state one bucket a cycle, over every bucket.
// No item is taken during the reset pass; configuration writes always are.
// ----------------------------------------------------------------------------
module hashed_set_assoc_hit_cache
    import hsac_pkg::*;
#(
    parameter int BUCKET_BITS = 14,
    parameter int WAYS        = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request items
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [2:0]       i_command,
    input  logic [KEY_W-1:0] i_key_address,
    // result items
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_status,
    output logic [HIT_W-1:0] o_hit_count,
    // configuration writes
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data
);

`include "hashed_set_assoc_hit_cache_macros.svh"

    localparam int QW = $bits(t_req) + BUCKET_BITS;

    logic        r_cache_on;
    logic [31:0] r_hash_seed;

    logic                   fr_ready, init;
    logic                   f_valid, f_ready, q_valid, q_ready;
    t_req                   f_req, q_req;
    logic [BUCKET_BITS-1:0] f_bkt, q_bkt;
    logic [QW-1:0]          q_data;

    // config registers; the user writes them only while the block is quiet, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_on  <= 1'b0;
            r_hash_seed <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_CACHE_ON) begin
                r_cache_on <= i_cfg_data[0];
            end else if (i_cfg_index == REG_HASH_SEED) begin
                r_hash_seed <= i_cfg_data;
            end
        end
    end

    // hold off items while the post-reset sweep runs
    assign o_in_ready = fr_ready && !init;

    hsac_front #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid && !init),
        .o_ready       (fr_ready),
        .i_command     (i_command),
        .i_key_address (i_key_address),
        .i_cache_on    (r_cache_on),
        .i_hash_seed   (r_hash_seed),
        .o_req_valid   (f_valid),
        .i_req_ready   (f_ready),
        .o_req         (f_req),
        .o_bkt         (f_bkt)
    );

    hsac_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_req, f_bkt}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    assign q_req = q_data[QW-1:BUCKET_BITS];
    assign q_bkt = q_data[BUCKET_BITS-1:0];

    hsac_back #(
        .BUCKET_BITS (BUCKET_BITS),
        .WAYS        (WAYS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_req       (q_req),
        .i_bkt       (q_bkt),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_hit_count (o_hit_count),
        .o_init      (init)
    );

    // no item enters while the reset sweep runs
    `HSAC_ASSERT_NOW(a_no_accept_in_init, init, !o_in_ready, "item accepted during init")
    // the reset sweep never produces a result
    `HSAC_ASSERT_NOW(a_no_result_in_init, init, !o_out_valid, "result during init")
    // back end only takes work when the result register can hold its answer
    `HSAC_ASSERT_NOW(a_pop_out_free, q_valid && q_ready, !o_out_valid || i_out_ready,
        "queue pop with result register blocked")

endmodule
